// File: rtl/pidsc_pkg.sv
// Package for the PID speed controller: widths, register indexes, reset values,
// configuration and divider handshake types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pidsc_pkg;

  // field and datapath widths
  localparam int DATA_W    = 32;                    // speeds, error, drive
  localparam int GAIN_W    = 31;                    // gains, dt, limits
  localparam int ACC_W     = 48;                    // error accumulator
  localparam int PROD_W    = GAIN_W + DATA_W;       // one multiplier product
  localparam int WIDE_W    = PROD_W + 16;           // gain times 48-bit magnitude
  localparam int SUM_W     = 64;                    // sum of clamped terms
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  // every internal term is clamped to this magnitude before the sum
  localparam logic [SUM_W-1:0] TERM_LIM = 64'h1000_0000_0000_0000;

  // control modes; codes above MODE_SEP hold the last drive
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SEP    = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_THRESH = 3'd7;

  // reset values: dt = 1.0, limits = 20000.0
  localparam logic [GAIN_W-1:0] TIME_STEP_RST = 31'd65536;
  localparam logic [GAIN_W-1:0] LIMIT_RST     = 31'd1310720000;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] time_step;
    logic [1:0]        control_mode;
    logic [GAIN_W-1:0] drive_limit;
    logic [GAIN_W-1:0] integral_limit;
    logic [GAIN_W-1:0] sep_threshold;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_ACC,
    S_ACCW,
    S_P,
    S_IL,
    S_IH,
    S_IS,
    S_IT,
    S_D,
    S_DIV,
    S_CLAMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [GAIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/pid_speed_controller.sv
// Top level of the PID speed controller: configuration registers and stream ports.
// Depends on pidsc_pkg and pidsc_core (which holds pidsc_mul and pidsc_div).
`timescale 1ns / 1ps

// Fixed-point PID speed controller: speeds, error and drive are signed Q16.16, gains, dt and
// limits unsigned Q15.16. Each input item carries a measured and a setpoint speed; each
// produces one drive item. Mode 0 integrates the raw error and clamps the drive to
// +-drive_limit; mode 1 clears the integral when the error magnitude exceeds
// separation_threshold, otherwise integrates error*dt, clamps the integral term to
// +-integral_limit and divides the derivative term by dt; modes 2 and 3 repeat the last
// drive without touching state. One 31x32 multiplier is shared by all products in sequence.
// Mode 1 adds an error*dt accumulate step and the serial divider (one quotient bit per cycle
// for 63 bits, then a step to take the quotient); a separated error skips the accumulate
// step, and dt = 0 skips the divider. Hold mode goes straight from idle to the output step.
// The input is not ready while an item is in work; a finished drive waits in the output
// register and the next item can be accepted meanwhile. Configuration must be written only
// while idle; the user is bound by this, and the block itself does not enforce it.

module pid_speed_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,   // [31:0] measured_speed, [63:32] setpoint
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [31:0] drive
  // configuration writes
  input  logic                            cfg_wr_en,
  input  logic [pidsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidsc_pkg::GAIN_W-1:0]    cfg_wdata
);

  logic [pidsc_pkg::GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r, time_step_r;
  logic [1:0]                   control_mode_r;
  logic [pidsc_pkg::GAIN_W-1:0] drive_limit_r, integral_limit_r, sep_threshold_r;
  pidsc_pkg::cfg_t              cfg;

  // register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r      <= '0;
      integ_gain_r     <= '0;
      deriv_gain_r     <= '0;
      time_step_r      <= pidsc_pkg::TIME_STEP_RST;
      control_mode_r   <= pidsc_pkg::MODE_NORMAL;
      drive_limit_r    <= pidsc_pkg::LIMIT_RST;
      integral_limit_r <= pidsc_pkg::LIMIT_RST;
      sep_threshold_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pidsc_pkg::REG_PROP_GAIN:  prop_gain_r      <= cfg_wdata;
        pidsc_pkg::REG_INTEG_GAIN: integ_gain_r     <= cfg_wdata;
        pidsc_pkg::REG_DERIV_GAIN: deriv_gain_r     <= cfg_wdata;
        pidsc_pkg::REG_TIME_STEP:  time_step_r      <= cfg_wdata;
        pidsc_pkg::REG_MODE:       control_mode_r   <= cfg_wdata[1:0];
        pidsc_pkg::REG_DRIVE_LIM:  drive_limit_r    <= cfg_wdata;
        pidsc_pkg::REG_INTEG_LIM:  integral_limit_r <= cfg_wdata;
        pidsc_pkg::REG_SEP_THRESH: sep_threshold_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.prop_gain      = prop_gain_r;
  assign cfg.integ_gain     = integ_gain_r;
  assign cfg.deriv_gain     = deriv_gain_r;
  assign cfg.time_step      = time_step_r;
  assign cfg.control_mode   = control_mode_r;
  assign cfg.drive_limit    = drive_limit_r;
  assign cfg.integral_limit = integral_limit_r;
  assign cfg.sep_threshold  = sep_threshold_r;

  pidsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_meas   (in_tdata[31:0]),
    .in_targ   (in_tdata[63:32]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_drive (out_tdata)
  );

endmodule

// File: rtl/pidsc_mul.sv
// Shared 31 x 32 unsigned multiplier with a registered product.
// Depends on pidsc_pkg for widths.
`timescale 1ns / 1ps

module pidsc_mul (
  input  logic                         clk,
  input  logic [pidsc_pkg::GAIN_W-1:0] a,
  input  logic [pidsc_pkg::DATA_W-1:0] b,
  output logic [pidsc_pkg::PROD_W-1:0] prod
);

  logic [pidsc_pkg::PROD_W-1:0] prod_r;

  // register every product; the sequencer picks the cycle it needs
  always_ff @(posedge clk) begin
    prod_r <= pidsc_pkg::PROD_W'(a) * pidsc_pkg::PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

// File: rtl/pidsc_div.sv
// Restoring serial divider, one quotient bit per cycle, 63-bit dividend by 31-bit divisor.
// Depends on pidsc_pkg for widths and the request/response types.
`timescale 1ns / 1ps

module pidsc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pidsc_pkg::div_req_t req,
  output pidsc_pkg::div_rsp_t rsp
);

  logic [pidsc_pkg::PROD_W-1:0]    q_r;
  logic [pidsc_pkg::GAIN_W-1:0]    rem_r;
  logic [pidsc_pkg::GAIN_W-1:0]    divisor_r;
  logic [pidsc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [pidsc_pkg::GAIN_W:0]      trial;
  logic [pidsc_pkg::GAIN_W:0]      trial_sub;
  logic                            take;

  // shift in the next dividend bit and try the subtraction
  assign trial     = {rem_r, q_r[pidsc_pkg::PROD_W-1]};
  assign trial_sub = trial - {1'b0, divisor_r};
  assign take      = (trial >= {1'b0, divisor_r});

  // control: count the bits, pulse done on the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= pidsc_pkg::DIV_CNT_W'(pidsc_pkg::PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pidsc_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits replace dividend bits in the same register
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r       <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[pidsc_pkg::PROD_W-2:0], take};
      rem_r <= take ? trial_sub[pidsc_pkg::GAIN_W-1:0] : trial[pidsc_pkg::GAIN_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// File: rtl/pidsc_core.sv
// Sequencer and datapath of the PID speed controller: error, accumulator, terms, clamps.
// Depends on pidsc_pkg, pidsc_mul (shared multiplier) and pidsc_div (serial divider).
`timescale 1ns / 1ps

module pidsc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pidsc_pkg::cfg_t              cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pidsc_pkg::DATA_W-1:0] in_meas,
  input  logic [pidsc_pkg::DATA_W-1:0] in_targ,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pidsc_pkg::DATA_W-1:0] out_drive
);

  localparam int DW = pidsc_pkg::DATA_W;
  localparam int AW = pidsc_pkg::ACC_W;
  localparam int PW = pidsc_pkg::PROD_W;
  localparam int WW = pidsc_pkg::WIDE_W;
  localparam int SW = pidsc_pkg::SUM_W;
  localparam logic signed [SW-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SW-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  // clamp a magnitude to the term limit and apply the sign
  function automatic logic signed [SW-1:0] signed_term(input logic [WW-1:0] mag,
                                                       input logic neg);
    logic [SW-1:0] m;
    if (mag > {(WW-SW)'(0), pidsc_pkg::TERM_LIM}) m = pidsc_pkg::TERM_LIM;
    else m = mag[SW-1:0];
    signed_term = neg ? -$signed(m) : $signed(m);
  endfunction

  // saturate a 49-bit sum to the 48-bit accumulator range
  function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW:0] s);
    if (s[AW] != s[AW-1]) sat_acc = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    else sat_acc = s[AW-1:0];
  endfunction

  pidsc_pkg::state_t state_r, state_nxt;

  logic signed [AW-1:0] acc_r;
  logic signed [DW-1:0] prev_r;
  logic signed [DW-1:0] last_r;
  logic [DW-1:0]        meas_r, targ_r;
  logic signed [DW-1:0] e_r;
  logic [DW-1:0]        emag_r, dmag_r;
  logic                 eneg_r, dneg_r;
  logic signed [SW-1:0] total_r;
  logic [WW-1:0]        wide_r;
  logic                 out_valid_r;
  logic [DW-1:0]        out_drive_r;

  logic [pidsc_pkg::GAIN_W-1:0] mul_a;
  logic [DW-1:0]                mul_b;
  logic [PW-1:0]                prod;
  pidsc_pkg::div_req_t          div_req;
  pidsc_pkg::div_rsp_t          div_rsp;

  logic signed [DW:0]   err_full;
  logic signed [DW-1:0] e_sat;
  logic signed [DW:0]   e_neg;
  logic [DW-1:0]        emag_c;
  logic signed [DW:0]   diff_c;
  logic signed [DW:0]   diff_neg;
  logic [DW-1:0]        dmag_c;
  logic signed [AW:0]   acc_plus_e;
  logic signed [AW:0]   inc_mag;
  logic signed [AW:0]   acc_plus_inc;
  logic signed [AW:0]   acc_neg;
  logic [AW-1:0]        acc_mag;
  logic                 hold_mode;
  logic                 is_normal;
  logic                 is_sep;
  logic                 sep_clear;
  logic                 div_needed;
  logic signed [SW-1:0] ilim, dlim;
  logic signed [SW-1:0] iterm_raw, iterm_c;
  logic signed [SW-1:0] pterm, dterm_mul, dterm_zero, dterm_div;
  logic signed [SW-1:0] total_cl;
  logic signed [DW-1:0] drive_val;

  assign hold_mode  = (cfg.control_mode > pidsc_pkg::MODE_SEP);
  assign is_normal  = (cfg.control_mode == pidsc_pkg::MODE_NORMAL);
  assign is_sep     = (cfg.control_mode == pidsc_pkg::MODE_SEP);
  assign sep_clear  = (emag_r > {1'b0, cfg.sep_threshold});
  assign div_needed = is_sep && (cfg.time_step != '0);

  // error, saturated to 32 bits, and its difference to the previous error
  assign err_full = $signed({targ_r[DW-1], targ_r}) - $signed({meas_r[DW-1], meas_r});
  always_comb begin
    if (err_full[DW] != err_full[DW-1])
      e_sat = err_full[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else
      e_sat = err_full[DW-1:0];
  end
  assign e_neg    = -$signed({e_sat[DW-1], e_sat});
  assign emag_c   = e_sat[DW-1] ? e_neg[DW-1:0] : e_sat;
  assign diff_c   = $signed({e_sat[DW-1], e_sat}) - $signed({prev_r[DW-1], prev_r});
  assign diff_neg = -diff_c;
  assign dmag_c   = diff_c[DW] ? diff_neg[DW-1:0] : diff_c[DW-1:0];

  // accumulator updates: raw error, or error times dt
  assign acc_plus_e   = $signed({acc_r[AW-1], acc_r}) + $signed({{(AW-DW+1){e_r[DW-1]}}, e_r});
  assign inc_mag      = $signed({2'b00, prod[PW-1:16]});
  assign acc_plus_inc = $signed({acc_r[AW-1], acc_r}) + (eneg_r ? -inc_mag : inc_mag);
  assign acc_neg      = -$signed({acc_r[AW-1], acc_r});
  assign acc_mag      = acc_r[AW-1] ? acc_neg[AW-1:0] : acc_r;

  // term values
  assign pterm     = signed_term({32'b0, prod[PW-1:16]}, eneg_r);
  assign iterm_raw = signed_term({16'b0, wide_r[WW-1:16]}, acc_r[AW-1]);
  assign ilim      = $signed({33'b0, cfg.integral_limit});
  assign dlim      = $signed({33'b0, cfg.drive_limit});
  always_comb begin
    iterm_c = iterm_raw;
    if (is_sep) begin
      if (iterm_raw > ilim) iterm_c = ilim;
      else if (iterm_raw < -ilim) iterm_c = -ilim;
    end
  end
  assign dterm_mul  = signed_term({32'b0, prod[PW-1:16]}, dneg_r);
  assign dterm_zero = signed_term((prod != '0) ? {(WW-SW)'(0), pidsc_pkg::TERM_LIM} : '0,
                                  dneg_r);
  assign dterm_div  = signed_term({16'b0, div_rsp.quot}, dneg_r);

  // final clamps: drive limit in normal mode, then 32-bit saturation
  always_comb begin
    total_cl = total_r;
    if (is_normal) begin
      if (total_r > dlim) total_cl = dlim;
      else if (total_r < -dlim) total_cl = -dlim;
    end
    if (total_cl > S32_MAX) drive_val = S32_MAX[DW-1:0];
    else if (total_cl < S32_MIN) drive_val = S32_MIN[DW-1:0];
    else drive_val = total_cl[DW-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      pidsc_pkg::S_ACC: begin
        mul_a = cfg.time_step;
        mul_b = emag_r;
      end
      pidsc_pkg::S_P: begin
        mul_a = cfg.prop_gain;
        mul_b = emag_r;
      end
      pidsc_pkg::S_IL: begin
        mul_a = cfg.integ_gain;
        mul_b = acc_mag[DW-1:0];
      end
      pidsc_pkg::S_IH: begin
        mul_a = cfg.integ_gain;
        mul_b = {{(2*DW-AW){1'b0}}, acc_mag[AW-1:DW]};
      end
      pidsc_pkg::S_IT: begin
        mul_a = cfg.deriv_gain;
        mul_b = dmag_r;
      end
      default: ;
    endcase
  end

  pidsc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_req.start    = (state_r == pidsc_pkg::S_D) && div_needed;
  assign div_req.dividend = prod;
  assign div_req.divisor  = cfg.time_step;

  pidsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pidsc_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidsc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hold_mode ? pidsc_pkg::S_DONE : pidsc_pkg::S_ERR;
      end
      pidsc_pkg::S_ERR:  state_nxt = pidsc_pkg::S_ACC;
      pidsc_pkg::S_ACC: begin
        state_nxt = (is_normal || sep_clear) ? pidsc_pkg::S_P : pidsc_pkg::S_ACCW;
      end
      pidsc_pkg::S_ACCW: state_nxt = pidsc_pkg::S_P;
      pidsc_pkg::S_P:    state_nxt = pidsc_pkg::S_IL;
      pidsc_pkg::S_IL:   state_nxt = pidsc_pkg::S_IH;
      pidsc_pkg::S_IH:   state_nxt = pidsc_pkg::S_IS;
      pidsc_pkg::S_IS:   state_nxt = pidsc_pkg::S_IT;
      pidsc_pkg::S_IT:   state_nxt = pidsc_pkg::S_D;
      pidsc_pkg::S_D: begin
        state_nxt = div_needed ? pidsc_pkg::S_DIV : pidsc_pkg::S_CLAMP;
      end
      pidsc_pkg::S_DIV: begin
        if (div_rsp.done) state_nxt = pidsc_pkg::S_CLAMP;
      end
      pidsc_pkg::S_CLAMP: state_nxt = pidsc_pkg::S_DONE;
      pidsc_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = pidsc_pkg::S_IDLE;
      end
      default: state_nxt = pidsc_pkg::S_IDLE;
    endcase
  end

  // controller state: accumulator, previous error, last drive
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
      last_r <= '0;
    end else begin
      case (state_r)
        pidsc_pkg::S_ACC: begin
          if (is_normal) acc_r <= sat_acc(acc_plus_e);
          else if (sep_clear) acc_r <= '0;
        end
        pidsc_pkg::S_ACCW: acc_r <= sat_acc(acc_plus_inc);
        pidsc_pkg::S_CLAMP: begin
          last_r <= drive_val;
          prev_r <= e_r;
        end
        default: ;
      endcase
    end
  end

  // working registers: latch the item, error fields, term sum
  always_ff @(posedge clk) begin
    case (state_r)
      pidsc_pkg::S_IDLE: begin
        meas_r <= in_meas;
        targ_r <= in_targ;
      end
      pidsc_pkg::S_ERR: begin
        e_r    <= e_sat;
        emag_r <= emag_c;
        eneg_r <= e_sat[DW-1];
        dmag_r <= dmag_c;
        dneg_r <= diff_c[DW];
      end
      pidsc_pkg::S_IL: total_r <= pterm;
      pidsc_pkg::S_IH: wide_r  <= {{(WW-PW){1'b0}}, prod};
      pidsc_pkg::S_IS: wide_r  <= wide_r + {prod[WW-33:0], 32'b0};
      pidsc_pkg::S_IT: total_r <= total_r + iterm_c;
      pidsc_pkg::S_D: begin
        if (is_normal) total_r <= total_r + dterm_mul;
        else if (!div_needed) total_r <= total_r + dterm_zero;
      end
      pidsc_pkg::S_DIV: begin
        if (div_rsp.done) total_r <= total_r + dterm_div;
      end
      default: ;
    endcase
  end

  // output register: hold the drive until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == pidsc_pkg::S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pidsc_pkg::S_DONE && (!out_valid_r || out_ready)) out_drive_r <= last_r;
  end

  assign in_ready  = (state_r == pidsc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // hold mode leaves the controller state alone and goes straight to output
  a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidsc_pkg::S_IDLE && in_valid && hold_mode) |=>
      (state_r == pidsc_pkg::S_DONE && acc_r == $past(acc_r) && last_r == $past(last_r)))
    else $error("hold mode changed controller state");

  a_prev_follows_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidsc_pkg::S_CLAMP) |=> (prev_r == $past(e_r)))
    else $error("previous error not updated from current error");

  a_div_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (is_sep && cfg.time_step != '0))
    else $error("divider started outside separation mode or with zero dt");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidsc_pkg::S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  a_normal_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pidsc_pkg::S_CLAMP && is_normal) |=>
      (last_r <= $signed({1'b0, cfg.drive_limit}) && last_r >= -$signed({1'b0, cfg.drive_limit})))
    else $error("normal-mode drive outside drive limit");

endmodule

// File: dv/pid_speed_controller_tb.sv
// Self-checking testbench for pid_speed_controller: directed corners, then random speed items.
// Needs pidsc_pkg and the controller RTL; carries its own Q16.16 predictor of the drive.
`timescale 1ns / 1ps

module pid_speed_controller_tb;

  // hold modes have no name in the package
  localparam logic [1:0] MODE_HOLD     = 2'd2;
  localparam logic [1:0] MODE_HOLD_ALT = 2'd3;

  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] SPD_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] SPD_MIN  = 32'h8000_0000;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 85;

  typedef struct {
    logic [31:0] meas;
    logic [31:0] targ;
    bit          drain;   // wait for all drives before sending this item
  } speed_item_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [63:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [31:0]                     out_tdata;
  logic                            cfg_wr_en = 1'b0;
  logic [pidsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pidsc_pkg::GAIN_W-1:0]    cfg_wdata = '0;

  speed_item_t speed_q[$];
  logic [31:0] drive_expect[$];
  int          items_queued = 0;
  int          items_taken = 0;
  int          drives_seen = 0;
  int          n_mismatch = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          in_took = 1'b0;

  // predictor state and register copy
  pidsc_pkg::cfg_t ctl;
  longint          prev_error;
  longint          err_sum;
  longint          last_drive;

  pid_speed_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] measured_speed, [63:32] setpoint
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] drive
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // limit a magnitude to the term bound and apply the sign
  function automatic longint cap_term(input logic [127:0] mag, input bit neg);
    if (mag > 128'(pidsc_pkg::TERM_LIM)) mag = 128'(pidsc_pkg::TERM_LIM);
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  // gain times value, magnitude truncated by 16 bits
  function automatic longint q16_product(input logic [30:0] gain, input longint x);
    logic [127:0] full;
    full = (128'(gain) * 128'(magnitude(x))) >> 16;
    return cap_term(full, x < 0);
  endfunction

  function automatic logic [31:0] compute_drive(input logic signed [31:0] meas,
                                                input logic signed [31:0] targ);
    longint      e;
    longint      d;
    longint      total;
    longint      iterm;
    logic [63:0] num;
    logic [63:0] quot;
    if (ctl.control_mode > pidsc_pkg::MODE_SEP) return last_drive[31:0];
    e = clip(longint'(targ) - longint'(meas), S32_LO, S32_HI);
    d = e - prev_error;
    if (ctl.control_mode == pidsc_pkg::MODE_NORMAL) begin
      err_sum = clip(err_sum + e, ACC_LO, ACC_HI);
      total = q16_product(ctl.prop_gain, e) + q16_product(ctl.integ_gain, err_sum)
            + q16_product(ctl.deriv_gain, d);
      total = clip(total, -longint'(ctl.drive_limit), longint'(ctl.drive_limit));
    end else begin
      // integral separation: drop the sum on a large error
      if (magnitude(e) > 64'(ctl.sep_threshold))
        err_sum = 0;
      else
        err_sum = clip(err_sum + q16_product(ctl.time_step, e), ACC_LO, ACC_HI);
      iterm = clip(q16_product(ctl.integ_gain, err_sum),
                   -longint'(ctl.integral_limit), longint'(ctl.integral_limit));
      num = 64'(ctl.deriv_gain) * magnitude(d);
      if (ctl.time_step == '0)
        quot = (num != 0) ? pidsc_pkg::TERM_LIM : 64'd0;
      else
        quot = num / 64'(ctl.time_step);
      total = q16_product(ctl.prop_gain, e) + iterm + cap_term(128'(quot), d < 0);
    end
    total = clip(total, S32_LO, S32_HI);
    prev_error = e;
    last_drive = total;
    return total[31:0];
  endfunction

  // ---------------------------------------------------------------- driver and receiver

  // present the next item once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (speed_q.size() != 0 && !(speed_q[0].drain && drive_expect.size() != 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata  <= {speed_q[0].targ, speed_q[0].meas};
        in_tvalid <= 1'b1;
        void'(speed_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string msg);
    $display("[%0t] drive check: %s", $realtime, msg);
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        drive_expect.push_back(compute_drive(in_tdata[31:0], in_tdata[63:32]));
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (drive_expect.size() == 0) begin
          report_mismatch($sformatf("drive %h with nothing pending", out_tdata));
        end else if (out_tdata !== drive_expect[0]) begin
          report_mismatch($sformatf("drive %0d got %h expected %h",
                                    drives_seen, out_tdata, drive_expect[0]));
        end
        if (drive_expect.size() != 0) void'(drive_expect.pop_front());
        drives_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic push_item(input logic [31:0] meas, input logic [31:0] targ,
                           input bit drain = 1'b0);
    speed_item_t it;
    it.meas  = meas;
    it.targ  = targ;
    it.drain = drain;
    speed_q.push_back(it);
    items_queued++;
  endtask

  // hold until every item is taken and every drive has come back
  task automatic settle();
    while (speed_q.size() != 0 || items_taken != items_queued || drive_expect.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [pidsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [30:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pidsc_pkg::REG_PROP_GAIN:  ctl.prop_gain      = val;
      pidsc_pkg::REG_INTEG_GAIN: ctl.integ_gain     = val;
      pidsc_pkg::REG_DERIV_GAIN: ctl.deriv_gain     = val;
      pidsc_pkg::REG_TIME_STEP:  ctl.time_step      = val;
      pidsc_pkg::REG_MODE:       ctl.control_mode   = val[1:0];
      pidsc_pkg::REG_DRIVE_LIM:  ctl.drive_limit    = val;
      pidsc_pkg::REG_INTEG_LIM:  ctl.integral_limit = val;
      pidsc_pkg::REG_SEP_THRESH: ctl.sep_threshold  = val;
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] corner_speed();
    case ($urandom_range(0, 4))
      0:       return SPD_MIN;
      1:       return SPD_MAX;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  function automatic logic [30:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 31'd1;
      1:       return GAIN_MAX;
      2:       return 31'($urandom) | 31'd1;
      default: return 31'($urandom_range(1 << 12, 1 << 18));
    endcase
  endfunction

  function automatic logic [30:0] pick_limit(input int unsigned span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return 31'($urandom);
      default: return 31'($urandom_range(0, span));
    endcase
  endfunction

  // rewrite every register with a random setting
  task automatic random_setup();
    logic [1:0] mode;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mode = pidsc_pkg::MODE_NORMAL;
      4, 5, 6, 7: mode = pidsc_pkg::MODE_SEP;
      8:          mode = MODE_HOLD;
      default:    mode = MODE_HOLD_ALT;
    endcase
    write_reg(pidsc_pkg::REG_PROP_GAIN,  pick_gain());
    write_reg(pidsc_pkg::REG_INTEG_GAIN, pick_gain());
    write_reg(pidsc_pkg::REG_DERIV_GAIN, pick_gain());
    write_reg(pidsc_pkg::REG_TIME_STEP,  pick_step());
    write_reg(pidsc_pkg::REG_MODE,       {29'($urandom), mode});
    write_reg(pidsc_pkg::REG_DRIVE_LIM,  pick_limit(1 << 26));
    write_reg(pidsc_pkg::REG_INTEG_LIM,  pick_limit(1 << 26));
    write_reg(pidsc_pkg::REG_SEP_THRESH, pick_limit(1 << 24));
    cfg_release();
  endtask

  // mostly small tracking errors around a random speed, some wide and corner items
  task automatic push_random(input bit drain);
    logic [31:0] meas;
    logic [31:0] targ;
    int unsigned span;
    case ($urandom_range(0, 9))
      0: begin
        meas = $urandom;
        targ = $urandom;
      end
      1: begin
        meas = corner_speed();
        targ = corner_speed();
      end
      default: begin
        span = 1 << (4 * $urandom_range(2, 6));
        meas = $urandom;
        targ = meas + $urandom_range(0, span) - span / 2;
      end
    endcase
    push_item(meas, targ, drain);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int drain_at;
    ctl = '0;
    ctl.time_step      = pidsc_pkg::TIME_STEP_RST;
    ctl.drive_limit    = pidsc_pkg::LIMIT_RST;
    ctl.integral_limit = pidsc_pkg::LIMIT_RST;
    prev_error = 0;
    err_sum    = 0;
    last_drive = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 76;

    // reset settings: zero gains, sum still moves
    push_item(SPD_MIN, SPD_MAX);
    push_item(SPD_MAX, SPD_MIN);
    push_item(32'h0, 32'h0);
    settle();

    // normal mode, saturated errors and a wide-open drive clamp
    write_reg(pidsc_pkg::REG_PROP_GAIN,  31'd65536);
    write_reg(pidsc_pkg::REG_INTEG_GAIN, 31'd1);
    write_reg(pidsc_pkg::REG_DERIV_GAIN, GAIN_MAX);
    write_reg(pidsc_pkg::REG_DRIVE_LIM,  GAIN_MAX);
    cfg_release();
    push_item(32'h0, SPD_MAX);
    push_item(SPD_MIN, SPD_MAX);
    push_item(SPD_MAX, SPD_MIN);
    push_item(32'd5, 32'd5);
    settle();

    // tight drive clamp
    write_reg(pidsc_pkg::REG_INTEG_GAIN, 31'd65536);
    write_reg(pidsc_pkg::REG_DRIVE_LIM,  31'h1000);
    cfg_release();
    push_item(32'h0064_0000, 32'h0);
    push_item(32'h0, 32'h0064_0000);
    settle();

    // separation mode: sum saturates, integral clamps, then a large error clears it
    write_reg(pidsc_pkg::REG_PROP_GAIN,  31'd0);
    write_reg(pidsc_pkg::REG_DERIV_GAIN, 31'd65536);
    write_reg(pidsc_pkg::REG_TIME_STEP,  GAIN_MAX);
    write_reg(pidsc_pkg::REG_MODE,       31'(pidsc_pkg::MODE_SEP));
    write_reg(pidsc_pkg::REG_INTEG_LIM,  GAIN_MAX);
    write_reg(pidsc_pkg::REG_SEP_THRESH, GAIN_MAX);
    cfg_release();
    repeat (3) push_item(32'h0, SPD_MAX);
    push_item(32'h0, SPD_MIN);
    push_item(32'd1, 32'd0);
    settle();

    // zero time step: derivative goes full scale, sum gains nothing
    write_reg(pidsc_pkg::REG_TIME_STEP,  31'd0);
    write_reg(pidsc_pkg::REG_SEP_THRESH, 31'h0001_0000);
    write_reg(pidsc_pkg::REG_INTEG_LIM,  31'd0);
    cfg_release();
    push_item(32'h0, 32'h0);
    push_item(32'h0, 32'h0000_8000);
    push_item(32'h0, 32'h0000_8000);
    push_item(32'h0000_8000, 32'h0);
    settle();

    // both hold codes repeat the last drive
    write_reg(pidsc_pkg::REG_MODE, 31'(MODE_HOLD));
    cfg_release();
    push_item(SPD_MAX, SPD_MIN);
    push_item(32'h1234_5678, 32'h0);
    settle();
    write_reg(pidsc_pkg::REG_MODE, 31'(MODE_HOLD_ALT));
    cfg_release();
    push_item(32'h0, SPD_MAX);
    settle();

    // random phases, each with its own settings and one drained item
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 17;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setup();
      drain_at = $urandom_range(1, PHASE_ITEMS - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) push_random(i == drain_at);
      settle();
    end

    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // overall limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
